// ===== design/assert_macros.svh =====
// Assertion helpers for the RC4 engine.
// RC4_ASSERT_CLK: checked at each rising clock edge, off while reset is high.
// RC4_ASSERT_ALL: checked at each rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RC4_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RC4_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RC4_ASSERT_CLK(label, clk, rst, prop, msg)
`define RC4_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

// ===== design/rc4sc_pkg.sv =====
package rc4sc_pkg;

   localparam int BYTE_W                = 8;
   localparam int PERM_DEPTH            = 256;
   localparam int MAX_KEY_BYTES_DEFAULT = 256;

   localparam logic [BYTE_W-1:0] LAST_ENTRY = 8'hFF;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KS_CLEAR,
      ST_KS_READ,
      ST_READ_J,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } perm_wr_type;

endpackage

// ===== design/rc4sc_ram.sv =====
module rc4sc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rc4sc_perm.sv =====
`include "assert_macros.svh"

// Permutation store: RAM plus one valid bit per entry. An entry never written
// since reset or the last clear reads as its own index (identity).
module rc4sc_perm import rc4sc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear_all,
   input  perm_wr_type       wr,
   input  logic [BYTE_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [PERM_DEPTH-1:0] valid_ff;
   logic [PERM_DEPTH-1:0] valid_in;
   logic                  rd_valid_ff;
   logic [BYTE_W-1:0]     rd_addr_ff;
   logic [BYTE_W-1:0]     ram_data;

   rc4sc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
      rd_addr_ff <= rd_addr;
   end

   assign rd_data = rd_valid_ff ? ram_data : rd_addr_ff;

   `RC4_ASSERT_ALL(a_clear_empties, clock, (reset || clear_all) |=> (valid_ff == '0), "valid bits survive a clear")

endmodule

// ===== design/rc4_stream_cipher.sv =====
// RC4 engine. Send key bytes with req_operation low; the byte marked
// req_key_last (stored if room remains, up to MAX_KEY_BYTES) starts the key
// schedule, which resets the permutation to identity and walks all 256
// entries on the single write port of the permutation RAM, stalling the
// input until the walk ends; it then clears both stream indices and the key
// length. Other key bytes leave the input free. A data item (req_operation
// high) stalls the input while it reads S[i], reads S[j], writes S[i] while
// reading S[S[i]+S[j]] and writes S[j]; its result then sits in the output
// register while the next item is taken in, or, while that register is
// full, waits in ST_HOLD with input stalled. Before any key is loaded the
// identity permutation is used. Key bytes past MAX_KEY_BYTES are dropped.
`include "assert_macros.svh"

module rc4_stream_cipher import rc4sc_pkg::*; #(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_key_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte
);

   localparam int KA_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);

   state_type         state_ff, state_in;
   logic              ks_mode_ff, ks_mode_in;
   logic [BYTE_W-1:0] i_ff, i_in;
   logic [BYTE_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0] k_ff, k_in;
   logic [KA_W-1:0]   kidx_ff, kidx_in;
   logic [CNT_W-1:0]  key_count_ff, key_count_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic [BYTE_W-1:0] sa_ff, sa_in;
   logic [BYTE_W-1:0] sj_ff, sj_in;
   logic [BYTE_W-1:0] t_ff, t_in;
   logic [BYTE_W-1:0] res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   logic              req_accept;
   logic              rsp_free;
   logic              perm_clear;
   perm_wr_type       perm_wr;
   logic [BYTE_W-1:0] perm_rd_addr;
   logic [BYTE_W-1:0] perm_rd_data;
   logic              key_wr_en;
   logic [BYTE_W-1:0] key_rd_data;
   logic [BYTE_W-1:0] a_addr;
   logic [BYTE_W-1:0] j_new;
   logic [BYTE_W-1:0] t_new;
   logic [BYTE_W-1:0] ks_byte;

   rc4sc_perm u_perm (
      .clock     (clock),
      .reset     (reset),
      .clear_all (perm_clear),
      .wr        (perm_wr),
      .rd_addr   (perm_rd_addr),
      .rd_data   (perm_rd_data)
   );

   rc4sc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_KEY_BYTES)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_count_ff[KA_W-1:0]),
      .wr_data (req_byte_value),
      .rd_addr (kidx_ff),
      .rd_data (key_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign a_addr     = ks_mode_ff ? k_ff : i_ff;

   always_comb begin
      state_in     = state_ff;
      ks_mode_in   = ks_mode_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kidx_in      = kidx_ff;
      key_count_in = key_count_ff;
      data_in      = data_ff;
      sa_in        = sa_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      perm_clear   = 1'b0;
      perm_wr      = '0;
      perm_rd_addr = i_ff + 8'd1;
      key_wr_en    = 1'b0;
      j_new        = j_ff + perm_rd_data + (ks_mode_ff ? key_rd_data : 8'd0);
      t_new        = sa_ff + perm_rd_data;
      // later write (S[j]) wins over the earlier one (S[i])
      if (t_ff == j_ff) begin
         ks_byte = sa_ff;
      end else if (t_ff == i_ff) begin
         ks_byte = sj_ff;
      end else begin
         ks_byte = perm_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               data_in = req_byte_value;
               if (req_operation == OP_DATA) begin
                  i_in       = i_ff + 8'd1;
                  ks_mode_in = 1'b0;
                  state_in   = ST_READ_J;
               end else begin
                  if (key_count_ff < CNT_W'(MAX_KEY_BYTES)) begin
                     key_wr_en    = 1'b1;
                     key_count_in = key_count_ff + CNT_W'(1);
                  end
                  if (req_key_last) begin
                     ks_mode_in = 1'b1;
                     state_in   = ST_KS_CLEAR;
                  end
               end
            end
         end
         ST_KS_CLEAR: begin
            perm_clear = 1'b1;
            j_in       = '0;
            k_in       = '0;
            kidx_in    = '0;
            state_in   = ST_KS_READ;
         end
         ST_KS_READ: begin
            perm_rd_addr = k_ff;
            state_in     = ST_READ_J;
         end
         ST_READ_J: begin
            sa_in        = perm_rd_data;
            j_in         = j_new;
            perm_rd_addr = j_new;
            state_in     = ST_SWAP_A;
         end
         ST_SWAP_A: begin
            sj_in        = perm_rd_data;
            perm_wr.en   = 1'b1;
            perm_wr.addr = a_addr;
            perm_wr.data = perm_rd_data;
            t_in         = t_new;
            perm_rd_addr = t_new;
            state_in     = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            perm_wr.en   = 1'b1;
            perm_wr.addr = j_ff;
            perm_wr.data = sa_ff;
            if (ks_mode_ff) begin
               if (k_ff == LAST_ENTRY) begin
                  i_in         = '0;
                  j_in         = '0;
                  key_count_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  k_in = k_ff + 8'd1;
                  if (CNT_W'(kidx_ff) + CNT_W'(1) == key_count_ff) begin
                     kidx_in = '0;
                  end else begin
                     kidx_in = kidx_ff + KA_W'(1);
                  end
                  state_in = ST_KS_READ;
               end
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ks_byte ^ data_ff;
               state_in     = ST_IDLE;
            end else begin
               res_in   = ks_byte ^ data_ff;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ks_mode_ff   <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         kidx_ff      <= '0;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ks_mode_ff   <= ks_mode_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         kidx_ff      <= kidx_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff     <= data_in;
      sa_ff       <= sa_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      res_ff      <= res_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   `RC4_ASSERT_CLK(a_hold_needs_busy_out, clock, reset, (state_ff == ST_HOLD) |-> rsp_valid_ff, "result held while output slot empty")
   `RC4_ASSERT_CLK(a_data_from_idle, clock, reset, (state_ff == ST_READ_J && !ks_mode_ff) |-> ($past(state_ff) == ST_IDLE), "data item entered mid-sequence")
   `RC4_ASSERT_CLK(a_schedule_done, clock, reset, (state_ff == ST_SWAP_B && ks_mode_ff && k_ff == LAST_ENTRY) |=> (state_ff == ST_IDLE && key_count_ff == '0 && i_ff == '0 && j_ff == '0), "key schedule end did not reset indices")

endmodule
